FILE: sv/rde_pkg.sv
// ----------------------------------------------------------------------------
// Raster draw engine package
// Shared command codes and controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package rde_pkg;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_RING   = 3'd1,
      KIND_DISC   = 3'd2,
      KIND_VERTEX = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   // Datapath operations commanded by the controller.
   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_LOAD       = 4'd1,  // capture command fields
      OP_CLR_STEP   = 4'd2,  // write one clear pixel, advance
      OP_RING_INIT  = 4'd3,  // set up ring of radius r+t
      OP_RING_PLOT  = 4'd4,  // plot octant point, advance octant
      OP_RING_ADV   = 4'd5,  // advance midpoint step
      OP_DISC_INIT  = 4'd6,
      OP_DISC_STEP  = 4'd7,  // test/plot one disc pixel
      OP_LINE_INIT  = 4'd8,  // set up edge (edge_close chooses endpoints)
      OP_LINE_PLOT  = 4'd9,  // plot one spread point
      OP_LINE_ADV   = 4'd10, // Bresenham step
      OP_VERT_BOOK  = 4'd11, // update polygon vertex bookkeeping
      OP_READ_ADDR  = 4'd12,
      OP_READ_DONE  = 4'd13
   } op_type;

   typedef struct packed {
      op_type op;
      logic   edge_close; // 1: edge from current to first vertex
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic ring_plot_last;  // last of eight octant points
      logic ring_done;       // y < x
      logic ring_thick_last; // last ring
      logic disc_last;
      logic disc_empty;
      logic line_plot_last;
      logic line_end;
      logic poly_open;
      logic thick_zero;
      logic vert_last;       // vertex closes the polygon
   } status_type;

endpackage

FILE: sv/rde_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: sv/rde_datapath.sv
// ----------------------------------------------------------------------------
// Raster draw engine datapath
// Shape walkers, clipping, pixel address generation and the frame memory.
// ----------------------------------------------------------------------------
module rde_datapath #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  rde_pkg::cmd_type   cmd,
   input  logic signed [11:0] req_pos_x,
   input  logic signed [11:0] req_pos_y,
   input  logic [9:0]         req_radius,
   input  logic [31:0]        req_draw_color,
   input  logic [4:0]         req_thickness,
   input  logic               req_last_vertex,
   output rde_pkg::status_type status,
   output logic [31:0]        pixel_value,
   output logic               read_hit
);
   localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // Coordinates fit in 16 signed bits for all shapes.
   logic signed [15:0] cx_ff, cy_ff;
   logic [9:0]  r_ff;
   logic [31:0] col_ff;
   logic [4:0]  th_ff;
   logic        last_ff;

   logic signed [11:0] fvx_ff, fvy_ff, pvx_ff, pvy_ff;
   logic        open_ff;

   // Shared walker registers.
   logic [AW-1:0]       clr_ff;
   logic [4:0]          t_ff;
   logic signed [15:0]  wx_ff, wy_ff;   // ring x,y or line x,y or disc offsets
   logic signed [23:0]  d_ff;           // ring decision / line error
   logic [2:0]          oct_ff;
   logic signed [15:0]  xlo_ff, xhi_ff, yhi_ff;
   logic signed [15:0]  ex_ff, ey_ff, dx_ff, dy_ff;
   logic signed [1:0]   sx_ff, sy_ff;
   logic [1:0]          arm_ff;
   logic [21:0]         rr_ff;
   logic [31:0]         hit_val_ff;
   logic                hit_ff;

   // Plot port.
   logic               wr_en;
   logic signed [15:0] px, py;
   logic [AW-1:0]      addr;
   logic [31:0]        wdata;
   logic [31:0]        rdata;
   logic               in_frame;

   always_comb begin
      in_frame = (px >= 0) && (px < 16'(FRAME_WIDTH)) && (py >= 0)
                 && (py < 16'(FRAME_HEIGHT));
   end

   // Radius as a signed value for the clipping compares.
   logic signed [15:0] rs;
   always_comb begin
      rs = $signed({6'd0, r_ff});
   end

   // Octant point of the ring.
   logic signed [15:0] rpx, rpy;
   always_comb begin
      unique case (oct_ff)
         3'd0: begin rpx = cx_ff + wx_ff; rpy = cy_ff + wy_ff; end
         3'd1: begin rpx = cx_ff - wx_ff; rpy = cy_ff + wy_ff; end
         3'd2: begin rpx = cx_ff + wx_ff; rpy = cy_ff - wy_ff; end
         3'd3: begin rpx = cx_ff - wx_ff; rpy = cy_ff - wy_ff; end
         3'd4: begin rpx = cx_ff + wy_ff; rpy = cy_ff + wx_ff; end
         3'd5: begin rpx = cx_ff - wy_ff; rpy = cy_ff + wx_ff; end
         3'd6: begin rpx = cx_ff + wy_ff; rpy = cy_ff - wx_ff; end
         default: begin rpx = cx_ff - wy_ff; rpy = cy_ff - wx_ff; end
      endcase
   end

   // Spread point of the line.
   logic signed [15:0] lpx, lpy, tt;
   always_comb begin
      tt = 16'($unsigned(t_ff));
      unique case (arm_ff)
         2'd0: begin lpx = wx_ff + tt; lpy = wy_ff; end
         2'd1: begin lpx = wx_ff; lpy = wy_ff + tt; end
         2'd2: begin lpx = wx_ff - tt; lpy = wy_ff; end
         default: begin lpx = wx_ff; lpy = wy_ff - tt; end
      endcase
   end

   // Disc test: one squared distance per cycle.
   logic [21:0] dsq;
   logic signed [15:0] ax, ay;
   always_comb begin
      ax = wx_ff[15] ? -wx_ff : wx_ff;
      ay = wy_ff[15] ? -wy_ff : wy_ff;
      dsq = 22'(ax[10:0]) * 22'(ax[10:0]) + 22'(ay[10:0]) * 22'(ay[10:0]);
   end

   logic [AW-1:0] lin_addr;
   always_comb begin
      lin_addr = AW'(int'(py[10:0]) * FRAME_WIDTH + int'(px[10:0]));
   end

   always_comb begin
      wr_en = 1'b0;
      px    = '0;
      py    = '0;
      wdata = col_ff;
      unique case (cmd.op)
         rde_pkg::OP_RING_PLOT: begin px = rpx; py = rpy; end
         rde_pkg::OP_DISC_STEP: begin px = cx_ff + wx_ff; py = cy_ff + wy_ff; end
         rde_pkg::OP_LINE_PLOT: begin px = lpx; py = lpy; end
         rde_pkg::OP_READ_ADDR: begin px = cx_ff; py = cy_ff; end
         default: ;
      endcase
      unique case (cmd.op)
         rde_pkg::OP_CLR_STEP:  wr_en = 1'b1;
         rde_pkg::OP_RING_PLOT: wr_en = in_frame;
         rde_pkg::OP_DISC_STEP: wr_en = in_frame && (dsq <= rr_ff);
         rde_pkg::OP_LINE_PLOT: wr_en = in_frame;
         default: ;
      endcase
      addr = (cmd.op == rde_pkg::OP_CLR_STEP) ? clr_ff : lin_addr;
   end

   rde_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_frame (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wdata),
      .rd_data(rdata)
   );

   logic signed [23:0] e2;
   always_comb begin
      e2 = d_ff <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvx_ff <= '0; fvy_ff <= '0; pvx_ff <= '0; pvy_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            rde_pkg::OP_LOAD: begin
               cx_ff <= 16'(req_pos_x); cy_ff <= 16'(req_pos_y);
               r_ff <= req_radius; col_ff <= req_draw_color;
               th_ff <= req_thickness; last_ff <= req_last_vertex;
               clr_ff <= '0; t_ff <= '0;
               hit_ff <= 1'b0; hit_val_ff <= '0;
            end
            rde_pkg::OP_CLR_STEP: clr_ff <= clr_ff + 1'b1;
            rde_pkg::OP_RING_INIT: begin
               wx_ff <= '0;
               wy_ff <= 16'(r_ff) + 16'(t_ff);
               d_ff  <= 24'sd3 - 24'(2 * (11'(r_ff) + 11'(t_ff)));
               oct_ff <= '0;
            end
            rde_pkg::OP_RING_PLOT: oct_ff <= oct_ff + 1'b1;
            rde_pkg::OP_RING_ADV: begin
               wx_ff <= wx_ff + 1'b1;
               if (d_ff > 0) begin
                  wy_ff <= wy_ff - 1'b1;
                  d_ff <= d_ff + 24'(4 * (wx_ff + 16'sd1 - wy_ff + 16'sd1)) + 24'sd10;
               end else begin
                  d_ff <= d_ff + 24'(4 * (wx_ff + 16'sd1)) + 24'sd6;
               end
               if (wy_ff - (d_ff > 0 ? 16'sd1 : 16'sd0) < wx_ff + 16'sd1)
                  t_ff <= t_ff + 1'b1;
            end
            rde_pkg::OP_DISC_INIT: begin
               rr_ff <= 22'(r_ff) * 22'(r_ff);
               xlo_ff <= (cx_ff - rs < 0) ? -cx_ff : -rs;
               xhi_ff <= (cx_ff + rs > 16'(FRAME_WIDTH - 1))
                         ? 16'(FRAME_WIDTH - 1) - cx_ff : rs;
               yhi_ff <= (cy_ff + rs > 16'(FRAME_HEIGHT - 1))
                         ? 16'(FRAME_HEIGHT - 1) - cy_ff : rs;
               wy_ff <= (cy_ff - rs < 0) ? -cy_ff : -rs;
               wx_ff <= (cx_ff - rs < 0) ? -cx_ff : -rs;
            end
            rde_pkg::OP_DISC_STEP: begin
               if (wx_ff >= xhi_ff) begin
                  wx_ff <= xlo_ff; wy_ff <= wy_ff + 1'b1;
               end else begin
                  wx_ff <= wx_ff + 1'b1;
               end
            end
            rde_pkg::OP_LINE_INIT: begin
               logic signed [15:0] x1, y1, x2, y2;
               x1 = cmd.edge_close ? cx_ff : 16'(pvx_ff);
               y1 = cmd.edge_close ? cy_ff : 16'(pvy_ff);
               x2 = cmd.edge_close ? 16'(fvx_ff) : cx_ff;
               y2 = cmd.edge_close ? 16'(fvy_ff) : cy_ff;
               dx_ff <= (x2 > x1) ? x2 - x1 : x1 - x2;
               dy_ff <= (y2 > y1) ? y2 - y1 : y1 - y2;
               sx_ff <= (x1 < x2) ? 2'sd1 : -2'sd1;
               sy_ff <= (y1 < y2) ? 2'sd1 : -2'sd1;
               d_ff  <= 24'((x2 > x1 ? x2 - x1 : x1 - x2) - (y2 > y1 ? y2 - y1 : y1 - y2));
               wx_ff <= x1; wy_ff <= y1; ex_ff <= x2; ey_ff <= y2;
               t_ff <= '0; arm_ff <= '0;
            end
            rde_pkg::OP_LINE_PLOT: begin
               arm_ff <= arm_ff + 1'b1;
               if (arm_ff == 2'd3) t_ff <= t_ff + 1'b1;
            end
            rde_pkg::OP_LINE_ADV: begin
               logic signed [15:0] nlx, nly;
               nlx = wx_ff; nly = wy_ff;
               if (e2 > -24'(dy_ff) && e2 < 24'(dx_ff))
                  d_ff <= d_ff - 24'(dy_ff) + 24'(dx_ff);
               else if (e2 > -24'(dy_ff))
                  d_ff <= d_ff - 24'(dy_ff);
               else if (e2 < 24'(dx_ff))
                  d_ff <= d_ff + 24'(dx_ff);
               if (e2 > -24'(dy_ff)) nlx = wx_ff + 16'(sx_ff);
               if (e2 < 24'(dx_ff))  nly = wy_ff + 16'(sy_ff);
               wx_ff <= nlx; wy_ff <= nly;
               t_ff <= '0; arm_ff <= '0;
            end
            rde_pkg::OP_VERT_BOOK: begin
               if (!open_ff) begin
                  fvx_ff <= cx_ff[11:0]; fvy_ff <= cy_ff[11:0];
                  open_ff <= 1'b1;
               end
               pvx_ff <= cx_ff[11:0]; pvy_ff <= cy_ff[11:0];
               if (last_ff) begin
                  open_ff <= 1'b0;
                  if (!open_ff) begin
                     fvx_ff <= cx_ff[11:0]; fvy_ff <= cy_ff[11:0];
                  end
               end
            end
            rde_pkg::OP_READ_ADDR: hit_ff <= in_frame;
            rde_pkg::OP_READ_DONE: hit_val_ff <= hit_ff ? rdata : 32'd0;
            default: ;
         endcase
      end
   end

   always_comb begin
      status.clr_last        = (clr_ff == AW'(DEPTH - 1));
      status.ring_plot_last  = (oct_ff == 3'd7);
      status.ring_done       = (wy_ff < wx_ff);
      status.ring_thick_last = (t_ff >= th_ff);
      status.disc_last       = (wx_ff >= xhi_ff) && (wy_ff >= yhi_ff);
      status.disc_empty      = (xlo_ff > xhi_ff) || (wy_ff > yhi_ff);
      status.line_plot_last  = (arm_ff == 2'd3) && (t_ff == th_ff - 5'd1);
      status.line_end        = (wx_ff == ex_ff) && (wy_ff == ey_ff);
      status.poly_open       = open_ff;
      status.thick_zero      = (th_ff == 5'd0);
      status.vert_last       = last_ff;
   end

   assign pixel_value = hit_val_ff;
   assign read_hit    = hit_ff;
endmodule

FILE: sv/rde_ctrl.sv
// ----------------------------------------------------------------------------
// Raster draw engine controller
// Sequences each command through the datapath and strobes the result.
// ----------------------------------------------------------------------------
module rde_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          req_kind,
   input  rde_pkg::status_type status,
   output rde_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_CLR, S_RING_INIT, S_RING_PLOT, S_RING_ADV,
      S_RING_CHK, S_DISC_INIT, S_DISC_CHK, S_DISC, S_VERT, S_LINE_INIT,
      S_LINE_PLOT, S_LINE_ADV, S_READ, S_READ_WAIT, S_DONE
   } state_type;

   state_type state_ff;
   logic [2:0] kind_ff;
   logic       close_ff;   // current edge is the closing edge
   logic       rsp_ff;

   always_comb begin
      cmd.op = rde_pkg::OP_NONE;
      cmd.edge_close = close_ff;
      unique case (state_ff)
         S_IDLE:      cmd.op = (start && !rsp_ff) ? rde_pkg::OP_LOAD : rde_pkg::OP_NONE;
         S_CLR:       cmd.op = rde_pkg::OP_CLR_STEP;
         S_RING_INIT: cmd.op = rde_pkg::OP_RING_INIT;
         S_RING_PLOT: cmd.op = rde_pkg::OP_RING_PLOT;
         S_RING_ADV:  cmd.op = rde_pkg::OP_RING_ADV;
         S_DISC_INIT: cmd.op = rde_pkg::OP_DISC_INIT;
         S_DISC:      cmd.op = rde_pkg::OP_DISC_STEP;
         S_VERT:      cmd.op = rde_pkg::OP_VERT_BOOK;
         S_LINE_INIT: cmd.op = rde_pkg::OP_LINE_INIT;
         S_LINE_PLOT: cmd.op = rde_pkg::OP_LINE_PLOT;
         S_LINE_ADV:  cmd.op = rde_pkg::OP_LINE_ADV;
         S_READ:      cmd.op = rde_pkg::OP_READ_ADDR;
         S_READ_WAIT: cmd.op = rde_pkg::OP_READ_DONE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff <= '0;
         close_ff <= 1'b0;
         rsp_ff <= 1'b0;
      end else begin
         rsp_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start && !rsp_ff) begin
               kind_ff <= req_kind;
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               unique case (kind_ff)
                  rde_pkg::KIND_CLEAR:  state_ff <= S_CLR;
                  rde_pkg::KIND_RING:   state_ff <= status.thick_zero ? S_DONE : S_RING_INIT;
                  rde_pkg::KIND_DISC:   state_ff <= S_DISC_INIT;
                  rde_pkg::KIND_VERTEX: begin
                     // The incoming edge is drawn first, and only when a
                     // polygon is already open and the thickness is nonzero.
                     close_ff <= 1'b0;
                     state_ff <= (status.poly_open && !status.thick_zero)
                                 ? S_LINE_INIT : S_VERT;
                  end
                  rde_pkg::KIND_READ:   state_ff <= S_READ;
                  default:              state_ff <= S_DONE;
               endcase
            end
            S_CLR: if (status.clr_last) state_ff <= S_DONE;
            S_RING_INIT: state_ff <= S_RING_PLOT;
            S_RING_PLOT: if (status.ring_plot_last) state_ff <= S_RING_ADV;
            S_RING_ADV: state_ff <= S_RING_CHK;
            S_RING_CHK: begin
               if (!status.ring_done) state_ff <= S_RING_PLOT;
               else state_ff <= status.ring_thick_last ? S_DONE : S_RING_INIT;
            end
            S_DISC_INIT: state_ff <= S_DISC_CHK;
            S_DISC_CHK: state_ff <= status.disc_empty ? S_DONE : S_DISC;
            S_DISC: if (status.disc_last) state_ff <= S_DONE;
            S_VERT: begin
               // Bookkeeping has captured the first vertex; a last vertex
               // with nonzero thickness then draws the closing edge back to it.
               if (status.vert_last && !status.thick_zero) begin
                  close_ff <= 1'b1;
                  state_ff <= S_LINE_INIT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_LINE_INIT: state_ff <= S_LINE_PLOT;
            S_LINE_PLOT: if (status.line_plot_last) begin
               if (status.line_end) state_ff <= close_ff ? S_DONE : S_VERT;
               else state_ff <= S_LINE_ADV;
            end
            S_LINE_ADV: state_ff <= S_LINE_PLOT;
            S_READ: state_ff <= S_READ_WAIT;
            S_READ_WAIT: state_ff <= S_DONE;
            S_DONE: begin
               rsp_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE) || rsp_ff;
   assign rsp_valid = rsp_ff;
endmodule

FILE: sv/raster_draw_engine_core.sv
// ----------------------------------------------------------------------------
// Raster draw engine core
// One item is in flight at a time. A read strobes after its address and wait
// states; a clear writes each frame pixel in turn. A ring plots eight octant
// points per midpoint step, a disc tests its scanned offsets one by one, an
// edge plots 4*thickness spread points per edge point. Busy covers the strobe
// cycle, so the next item is accepted the cycle after; the strobe cannot stall.
// Synchronous active-high reset clears control and polygon state only.
// ----------------------------------------------------------------------------
module raster_draw_engine_core #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [11:0] req_pos_x,
   input  logic signed [11:0] req_pos_y,
   input  logic [9:0]         req_radius,
   input  logic [31:0]        req_draw_color,
   input  logic [4:0]         req_thickness,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   output logic [31:0]        rsp_pixel_value,
   output logic               rsp_read_hit
);
   rde_pkg::cmd_type    cmd;
   rde_pkg::status_type status;

   rde_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   rde_datapath #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_radius     (req_radius),
      .req_draw_color (req_draw_color),
      .req_thickness  (req_thickness),
      .req_last_vertex(req_last_vertex),
      .status         (status),
      .pixel_value    (rsp_pixel_value),
      .read_hit       (rsp_read_hit)
   );
endmodule
